### design/shbo_pkg.sv
package shbo_pkg;

    localparam int WORD_BITS    = 32;
    localparam int SAMPLE_DEPTH = 256;
    localparam int TRACK_DEPTH  = 4096;

    // Fixed widths of the item fields.
    localparam int IN_WORD_BITS = 32;
    localparam int OFF_BITS     = 12;
    localparam int DIST_BITS    = 14;

    localparam int STORE_BITS = (WORD_BITS < IN_WORD_BITS) ? WORD_BITS : IN_WORD_BITS;
    localparam int PC_BITS    = $clog2(STORE_BITS + 1);
    localparam int SAMPLE_AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int TRACK_AW   = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int SCNT_BITS  = $clog2(SAMPLE_DEPTH + 1);
    localparam int TCNT_BITS  = $clog2(TRACK_DEPTH + 1);
    localparam int CMP_BITS   = (SCNT_BITS > TCNT_BITS) ? SCNT_BITS : TCNT_BITS;
    localparam int ACC_BITS   = $clog2(SAMPLE_DEPTH * STORE_BITS + 1);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_TRACK  = 2'd2,
        ACT_RUN    = 2'd3
    } action_t;

    typedef struct packed {
        action_t                 act;
        logic [IN_WORD_BITS-1:0] word;
    } cmd_t;

    // Tag that travels with each word pair through the compare pipeline.
    typedef struct packed {
        logic valid;
        logic last_word;
        logic last_off;
    } tag_t;

    function automatic logic [PC_BITS-1:0] popcount(input logic [STORE_BITS-1:0] v);
        logic [PC_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < STORE_BITS; i++)
        begin
            n = n + PC_BITS'(v[i]);
        end
        return n;
    endfunction

endpackage

### design/shbo_front.sv
module shbo_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    action,
    input  logic [31:0]   word,
    output logic          cmd_valid,
    output shbo_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import shbo_pkg::*;

    cmd_t                q_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0]  count_reg, count_next;
    logic                wr_en;
    logic                rd_en;
    cmd_t                cmd_in;

    always_comb
    begin
        cmd_in.act  = action_t'(action);
        cmd_in.word = word;
    end

    assign full      = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### design/shbo_engine.sv
module shbo_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  shbo_pkg::cmd_t                    cmd,
    output logic                              cmd_take,
    output logic                              empty,
    input  logic                              pop,
    output logic [shbo_pkg::OFF_BITS-1:0]     best_offset,
    output logic [shbo_pkg::DIST_BITS-1:0]    min_distance,
    output logic                              status
);
    import shbo_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    logic [STORE_BITS-1:0] sample_mem [SAMPLE_DEPTH];
    logic [STORE_BITS-1:0] track_mem  [TRACK_DEPTH];

    state_t                state_reg, state_next;
    logic [SCNT_BITS-1:0]  scnt_reg, scnt_next;
    logic [TCNT_BITS-1:0]  tcnt_reg, tcnt_next;
    logic [SAMPLE_AW-1:0]  j_reg, j_next;
    logic [TRACK_AW-1:0]   off_reg, off_next;
    logic [SAMPLE_AW-1:0]  jmax_reg, jmax_next;
    logic [TRACK_AW-1:0]   last_reg, last_next;
    tag_t                  t1_reg, t1_next;
    tag_t                  t2_reg;
    logic [TRACK_AW-1:0]   off1_reg, off2_reg;
    logic [PC_BITS-1:0]    pc_reg;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                  have_reg, have_next;
    logic [ACC_BITS-1:0]   best_dist_reg, best_dist_next;
    logic [TRACK_AW-1:0]   best_off_reg, best_off_next;
    logic                  res_valid_reg, res_valid_next;
    logic [OFF_BITS-1:0]   res_off_reg, res_off_next;
    logic [DIST_BITS-1:0]  res_dist_reg, res_dist_next;
    logic                  res_status_reg, res_status_next;

    logic [STORE_BITS-1:0] s_rd_reg, t_rd_reg;
    logic                  s_we, t_we;
    logic [SAMPLE_AW-1:0]  s_addr;
    logic [TRACK_AW-1:0]   t_addr;
    logic                  is_idle;
    logic                  bad_run;
    logic [CMP_BITS-1:0]   scnt_ext, tcnt_ext, span;
    logic                  issue_last_word, issue_last_off;
    logic [ACC_BITS-1:0]   sum;
    logic                  win, finish;
    logic                  popped;

    assign is_idle  = (state_reg == ST_IDLE);
    assign cmd_take = cmd_valid && is_idle && ((cmd.act != ACT_RUN) || !res_valid_reg);
    assign popped   = pop && res_valid_reg;

    assign scnt_ext = CMP_BITS'(scnt_reg);
    assign tcnt_ext = CMP_BITS'(tcnt_reg);
    assign span     = tcnt_ext - scnt_ext;
    assign bad_run  = (scnt_reg == '0) || (scnt_ext > tcnt_ext);

    assign s_we = cmd_take && (cmd.act == ACT_SAMPLE) && (scnt_reg < SCNT_BITS'(SAMPLE_DEPTH));
    assign t_we = cmd_take && (cmd.act == ACT_TRACK) && (tcnt_reg < TCNT_BITS'(TRACK_DEPTH));

    // While loading, the count is the write address; while scanning, the counters are.
    assign s_addr = is_idle ? scnt_reg[SAMPLE_AW-1:0] : j_reg;
    assign t_addr = is_idle ? tcnt_reg[TRACK_AW-1:0] : off_reg + TRACK_AW'(j_reg);

    assign issue_last_word = (j_reg == jmax_reg);
    assign issue_last_off  = (off_reg == last_reg);

    assign sum    = acc_reg + ACC_BITS'(pc_reg);
    assign win    = t2_reg.valid && t2_reg.last_word && (!have_reg || (sum < best_dist_reg));
    assign finish = t2_reg.valid && t2_reg.last_word && t2_reg.last_off;

    always_comb
    begin
        state_next      = state_reg;
        scnt_next       = scnt_reg;
        tcnt_next       = tcnt_reg;
        j_next          = j_reg;
        off_next        = off_reg;
        jmax_next       = jmax_reg;
        last_next       = last_reg;
        t1_next         = '0;
        acc_next        = acc_reg;
        have_next       = have_reg;
        best_dist_next  = best_dist_reg;
        best_off_next   = best_off_reg;
        res_valid_next  = popped ? 1'b0 : res_valid_reg;
        res_off_next    = res_off_reg;
        res_dist_next   = res_dist_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.act)
                        ACT_CLEAR:
                        begin
                            scnt_next = '0;
                            tcnt_next = '0;
                        end
                        ACT_SAMPLE:
                        begin
                            if (s_we)
                            begin
                                scnt_next = scnt_reg + 1'b1;
                            end
                        end
                        ACT_TRACK:
                        begin
                            if (t_we)
                            begin
                                tcnt_next = tcnt_reg + 1'b1;
                            end
                        end
                        ACT_RUN:
                        begin
                            if (bad_run)
                            begin
                                res_valid_next  = 1'b1;
                                res_off_next    = '0;
                                res_dist_next   = '0;
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                j_next     = '0;
                                off_next   = '0;
                                jmax_next  = SAMPLE_AW'(scnt_reg - 1'b1);
                                last_next  = TRACK_AW'(span);
                                acc_next   = '0;
                                have_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                t1_next.valid     = 1'b1;
                t1_next.last_word = issue_last_word;
                t1_next.last_off  = issue_last_off;
                if (issue_last_word)
                begin
                    j_next = '0;
                    if (issue_last_off)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        off_next = off_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    state_next      = ST_IDLE;
                    res_valid_next  = 1'b1;
                    res_off_next    = OFF_BITS'(win ? off2_reg : best_off_reg);
                    res_dist_next   = DIST_BITS'(win ? sum : best_dist_reg);
                    res_status_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Accumulate one word pair per cycle; close the offset on its last word.
        if (t2_reg.valid)
        begin
            if (t2_reg.last_word)
            begin
                acc_next  = '0;
                have_next = 1'b1;
                if (win)
                begin
                    best_dist_next = sum;
                    best_off_next  = off2_reg;
                end
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scnt_reg      <= '0;
            tcnt_reg      <= '0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scnt_reg      <= scnt_next;
            tcnt_reg      <= tcnt_next;
            t1_reg        <= t1_next;
            t2_reg        <= t1_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        off_reg        <= off_next;
        jmax_reg       <= jmax_next;
        last_reg       <= last_next;
        off1_reg       <= off_reg;
        off2_reg       <= off1_reg;
        pc_reg         <= popcount(s_rd_reg ^ t_rd_reg);
        acc_reg        <= acc_next;
        have_reg       <= have_next;
        best_dist_reg  <= best_dist_next;
        best_off_reg   <= best_off_next;
        res_off_reg    <= res_off_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            sample_mem[s_addr] <= cmd.word[STORE_BITS-1:0];
        end
        s_rd_reg <= sample_mem[s_addr];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            track_mem[t_addr] <= cmd.word[STORE_BITS-1:0];
        end
        t_rd_reg <= track_mem[t_addr];
    end

    assign empty        = !res_valid_reg;
    assign best_offset  = res_off_reg;
    assign min_distance = res_dist_reg;
    assign status       = res_status_reg;

endmodule

### design/sliding_hamming_best_offset.sv
// Channel  | Handshake          | Fields
// ---------+--------------------+---------------------------------------------
// input    | push / full        | action[1:0], word[31:0]
// result   | empty / pop        | best_offset[11:0], min_distance[13:0], status
//
// Clear and load items stream back to back through the back end while no search runs.
// A search over S sample and T track words steps through T - S + 1 offsets of S word
// pairs each: the single read port of each word store delivers one word pair per cycle,
// and two pipeline stages follow the last pair.
// Reset empties the command queue and zeroes both counts; store contents stay unknown.
// A four-entry command queue takes items while a search runs; a new search waits
// in it until the previous result has been popped.
module sliding_hamming_best_offset (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     action,
    input  logic [shbo_pkg::IN_WORD_BITS-1:0] word,
    output logic                           empty,
    input  logic                           pop,
    output logic [shbo_pkg::OFF_BITS-1:0]  best_offset,
    output logic [shbo_pkg::DIST_BITS-1:0] min_distance,
    output logic                           status
);
    import shbo_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    shbo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .word      (word),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    shbo_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .empty        (empty),
        .pop          (pop),
        .best_offset  (best_offset),
        .min_distance (min_distance),
        .status       (status)
    );

endmodule

### verif/sliding_hamming_best_offset_test.sv
`timescale 1ns / 100ps

module sliding_hamming_best_offset_test;

    import shbo_pkg::*;

    localparam logic [IN_WORD_BITS-1:0] WORD_KEEP =
        (WORD_BITS >= IN_WORD_BITS) ? {IN_WORD_BITS{1'b1}} :
        ((IN_WORD_BITS'(1) << WORD_BITS) - IN_WORD_BITS'(1));

    typedef struct packed {
        logic [OFF_BITS-1:0]  best_offset;
        logic [DIST_BITS-1:0] min_distance;
        logic                 status;
    } search_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [1:0]              action = 2'd0;
    logic [IN_WORD_BITS-1:0] word = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [OFF_BITS-1:0]     best_offset;
    logic [DIST_BITS-1:0]    min_distance;
    logic                    status;

    // Mirror of the two word stores and their fill counts.
    logic [IN_WORD_BITS-1:0] mirror_sample [SAMPLE_DEPTH];
    logic [IN_WORD_BITS-1:0] mirror_track [TRACK_DEPTH];
    int                      mirror_sample_len = 0;
    int                      mirror_track_len = 0;

    search_result_t expected_searches [$];
    search_result_t arrived;

    int errors = 0;
    int items_sent = 0;
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    int pop_hold = 0;
    int pop_gap = 0;

    sliding_hamming_best_offset dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .word         (word),
        .empty        (empty),
        .pop          (pop),
        .best_offset  (best_offset),
        .min_distance (min_distance),
        .status       (status)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 100)
        begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Applies one accepted item to the mirror and queues the search answer, if any.
    task automatic mirror_action(input action_t act, input logic [IN_WORD_BITS-1:0] w);
        search_result_t r;
        int             last;
        int             sum;
        int             best_sum;
        int             best_off;
        logic [IN_WORD_BITS-1:0] wk;
        wk = w & WORD_KEEP;
        case (act)
            ACT_CLEAR:
            begin
                mirror_sample_len = 0;
                mirror_track_len = 0;
            end
            ACT_SAMPLE:
            begin
                if (mirror_sample_len < SAMPLE_DEPTH)
                begin
                    mirror_sample[mirror_sample_len] = wk;
                    mirror_sample_len++;
                end
            end
            ACT_TRACK:
            begin
                if (mirror_track_len < TRACK_DEPTH)
                begin
                    mirror_track[mirror_track_len] = wk;
                    mirror_track_len++;
                end
            end
            default:
            begin
                r = '0;
                if (mirror_sample_len == 0 || mirror_sample_len > mirror_track_len)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    last = mirror_track_len - mirror_sample_len;
                    best_sum = -1;
                    best_off = 0;
                    for (int off = 0; off <= last; off++)
                    begin
                        sum = 0;
                        for (int j = 0; j < mirror_sample_len; j++)
                        begin
                            sum += $countones((mirror_track[off + j] ^ mirror_sample[j])
                                              & WORD_KEEP);
                        end
                        if (best_sum < 0 || sum < best_sum)
                        begin
                            best_sum = sum;
                            best_off = off;
                        end
                    end
                    r.best_offset  = best_off[OFF_BITS-1:0];
                    r.min_distance = best_sum[DIST_BITS-1:0];
                end
                expected_searches.insert(expected_searches.size(), r);
            end
        endcase
    endtask

    // Offers one item and returns at the edge that accepts it, with push left high.
    task automatic send_item(input action_t act, input logic [IN_WORD_BITS-1:0] w);
        if (send_idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        push   <= 1'b1;
        action <= act;
        word   <= w;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        mirror_action(act, w);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else if (pop_gap > 0)
        begin
            pop <= 1'b0;
            pop_gap--;
        end
        else if (recv_idle_on && $urandom_range(0, 9) == 0)
        begin
            pop <= 1'b0;
            pop_gap = $urandom_range(1, 12) - 1;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_searches.size() == 0)
            begin
                report_mismatch("result with nothing expected", 32'(best_offset), 32'd0);
            end
            else
            begin
                arrived = expected_searches.pop_front();
                if (best_offset !== arrived.best_offset)
                    report_mismatch("best_offset", 32'(best_offset),
                                    32'(arrived.best_offset));
                if (min_distance !== arrived.min_distance)
                    report_mismatch("min_distance", 32'(min_distance),
                                    32'(arrived.min_distance));
                if (status !== arrived.status)
                    report_mismatch("status", 32'(status), 32'(arrived.status));
            end
        end
    end

    // Runs on empty and short stores, equal lengths, and the word extremes.
    task automatic test_errors_and_equal_lengths();
        send_item(ACT_RUN, $urandom());
        send_item(ACT_SAMPLE, 32'h0000_0000);
        send_item(ACT_RUN, 32'hFFFF_FFFF);
        send_item(ACT_TRACK, 32'hFFFF_FFFF);
        send_item(ACT_RUN, 32'h0000_0000);
        send_item(ACT_SAMPLE, 32'hFFFF_FFFF);
        send_item(ACT_SAMPLE, 32'h0000_0000);
        send_item(ACT_RUN, $urandom());
        send_item(ACT_CLEAR, $urandom());
        send_item(ACT_TRACK, 32'h0F0F_0F0F);
        send_item(ACT_RUN, $urandom());
        send_item(ACT_SAMPLE, 32'hF0F0_F0F0);
        send_item(ACT_RUN, $urandom());
    endtask

    // Two zero-distance alignments past a mismatching start: the lower one wins.
    task automatic test_tie_lowest_offset();
        logic [IN_WORD_BITS-1:0] a;
        logic [IN_WORD_BITS-1:0] b;
        a = $urandom();
        b = $urandom();
        send_item(ACT_CLEAR, $urandom());
        send_item(ACT_SAMPLE, a);
        send_item(ACT_SAMPLE, b);
        send_item(ACT_TRACK, ~a);
        send_item(ACT_TRACK, a);
        send_item(ACT_TRACK, b);
        send_item(ACT_TRACK, a);
        send_item(ACT_TRACK, b);
        send_item(ACT_RUN, $urandom());
    endtask

    // Overfills the sample store; a fully inverted track gives the largest distance.
    task automatic test_sample_full();
        logic [IN_WORD_BITS-1:0] sent [SAMPLE_DEPTH];
        logic [IN_WORD_BITS-1:0] w;
        send_item(ACT_CLEAR, $urandom());
        for (int k = 0; k < SAMPLE_DEPTH + 4; k++)
        begin
            w = $urandom();
            if (k < SAMPLE_DEPTH)
                sent[k] = w;
            send_item(ACT_SAMPLE, w);
        end
        for (int k = 0; k < SAMPLE_DEPTH; k++)
        begin
            send_item(ACT_TRACK, ~sent[k]);
        end
        send_item(ACT_RUN, $urandom());
        for (int k = 0; k < 3; k++)
        begin
            send_item(ACT_TRACK, sent[k]);
        end
        send_item(ACT_RUN, $urandom());
    endtask

    // Overfills the track store with the only exact match at its last entry.
    task automatic test_track_full();
        logic [IN_WORD_BITS-1:0] key;
        key = $urandom();
        send_item(ACT_CLEAR, $urandom());
        send_item(ACT_SAMPLE, key);
        for (int k = 0; k < TRACK_DEPTH + 4; k++)
        begin
            if (k >= TRACK_DEPTH - 1)
                send_item(ACT_TRACK, key);
            else
                send_item(ACT_TRACK, key ^ (32'h1 << $urandom_range(0, 31)) ^ $urandom());
        end
        send_item(ACT_RUN, $urandom());
        send_item(ACT_SAMPLE, $urandom());
        send_item(ACT_RUN, $urandom());
    endtask

    // The receiver stops for a long stretch while searches keep coming.
    task automatic test_backpressure();
        push <= 1'b0;
        @(negedge clk);
        pop_hold = 400;
        @(posedge clk);
        send_item(ACT_CLEAR, $urandom());
        send_item(ACT_SAMPLE, $urandom());
        send_item(ACT_TRACK, $urandom());
        send_item(ACT_TRACK, $urandom());
        for (int k = 0; k < 8; k++)
        begin
            send_item(ACT_RUN, $urandom());
            if (k == 3)
                send_item(ACT_TRACK, $urandom());
        end
    endtask

    // Mostly complete load-and-search sequences with random content, some noise.
    task automatic test_random(input int target);
        logic [IN_WORD_BITS-1:0] smp [32];
        logic [IN_WORD_BITS-1:0] trk [64];
        int                      s_len;
        int                      t_len;
        int                      plant;
        int                      j;
        int                      n;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                s_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                if ($urandom_range(0, 9) == 0)
                    t_len = $urandom_range(0, s_len - 1);
                else
                    t_len = s_len + $urandom_range(0, 24);
                for (int k = 0; k < s_len; k++)
                begin
                    smp[k] = $urandom();
                end
                plant = (t_len >= s_len) ? $urandom_range(0, t_len - s_len) : t_len;
                for (int k = 0; k < t_len; k++)
                begin
                    j = $urandom_range(0, s_len - 1);
                    if (k >= plant && k < plant + s_len && $urandom_range(0, 1) == 0)
                        trk[k] = smp[k - plant];
                    else if ($urandom_range(0, 2) == 0)
                        trk[k] = $urandom();
                    else if ($urandom_range(0, 1) == 0)
                        trk[k] = smp[j];
                    else
                        trk[k] = smp[j] ^ (32'h1 << $urandom_range(0, 31))
                                        ^ (32'h1 << $urandom_range(0, 31));
                end
                send_item(ACT_CLEAR, $urandom());
                // Load order between the two stores does not matter to the search.
                if ($urandom_range(0, 1) == 0)
                begin
                    for (int k = 0; k < s_len; k++)
                        send_item(ACT_SAMPLE, smp[k]);
                    for (int k = 0; k < t_len; k++)
                        send_item(ACT_TRACK, trk[k]);
                end
                else
                begin
                    for (int k = 0; k < t_len; k++)
                        send_item(ACT_TRACK, trk[k]);
                    for (int k = 0; k < s_len; k++)
                        send_item(ACT_SAMPLE, smp[k]);
                end
                send_item(ACT_RUN, $urandom());
                if ($urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        send_item(ACT_TRACK, smp[$urandom_range(0, s_len - 1)]);
                    send_item(ACT_RUN, $urandom());
                end
                if ($urandom_range(0, 7) == 0)
                    send_item(ACT_RUN, $urandom());
            end
            else
            begin
                n = $urandom_range(3, 10);
                for (int k = 0; k < n; k++)
                begin
                    send_item(action_t'($urandom_range(0, 3)), $urandom());
                end
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        test_errors_and_equal_lengths();
        test_tie_lowest_offset();
        test_sample_full();
        test_track_full();
        test_backpressure();
        test_random(items_sent + 1500);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random(items_sent + 300);
        push <= 1'b0;
        while (expected_searches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (600) @(posedge clk);
        if (errors == 0)
        begin
            $display("sliding_hamming_best_offset_test: clean");
        end
        else
        begin
            $display("sliding_hamming_best_offset_test: errors");
        end
        $finish;
    end

    initial
    begin
        #24000000;
        $display("sliding_hamming_best_offset_test: errors");
        $finish;
    end

endmodule
